@@ rtl/core/assert_macros.svh @@
// assert_macros.svh: assertion macros shared by the checker files.
// No dependencies; include by bare file name.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication, quiet while reset is asserted
`define ASSERT_IMPLIES(label, clk, rst_n, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
		else $error(msg);

// Next-cycle implication, quiet while reset is asserted
`define ASSERT_NEXT(label, clk, rst_n, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

@@ rtl/core/hsvrgb_pkg.sv @@
// hsvrgb_pkg: types and constants of the HSV to RGB pixel converter.
// No dependencies; used by hsvrgb_hue, hsvrgb_chan and hsv_to_rgb_pixel.
package hsvrgb_pkg;

	// Radians to sextants (6/pi), unsigned Q.32, worked out at elaboration
	localparam logic [32:0] SEXT_SCALE = 33'((64'd600000000 << 32) / 64'd314159265);

	// One sextant in Q.16
	localparam logic [16:0] ONE_Q16 = 17'd65536;

	// Hue sextants, 60 degrees each
	typedef enum logic [2:0] {
		SEXT_RED_YEL = 3'd0,
		SEXT_YEL_GRN = 3'd1,
		SEXT_GRN_CYN = 3'd2,
		SEXT_CYN_BLU = 3'd3,
		SEXT_BLU_MAG = 3'd4,
		SEXT_MAG_RED = 3'd5
	} sextant_t;

	// Load enables of the four pipeline stages
	typedef struct packed {
		logic s1;
		logic s2;
		logic s3;
		logic s4;
	} stage_en_t;

endpackage

@@ rtl/core/hsvrgb_if.sv @@
// hsvrgb_if: valid/ready channels for HSV pixel words in and RGB words out.
// Depends on nothing but the payload widths of the block.
interface hsvrgb_in_if;
	logic               valid;
	logic               ready;
	logic signed [15:0] hue_angle;
	logic        [16:0] saturation;
	logic        [16:0] brightness;

	modport source (output valid, hue_angle, saturation, brightness, input ready);
	modport sink   (input valid, hue_angle, saturation, brightness, output ready);
endinterface

interface hsvrgb_out_if;
	logic       valid;
	logic       ready;
	logic [7:0] red;
	logic [7:0] green;
	logic [7:0] blue;

	modport source (output valid, red, green, blue, input ready);
	modport sink   (input valid, red, green, blue, output ready);
endinterface

@@ rtl/core/hsvrgb_hue.sv @@
// hsvrgb_hue: hue path, radians to sextant index and 16-bit fraction (stages 1-2).
// Depends on hsvrgb_pkg.
module hsvrgb_hue (
	input  logic                  clk,
	input  hsvrgb_pkg::stage_en_t en,
	input  logic signed [15:0]    hue_angle,
	output hsvrgb_pkg::sextant_t  sext_s2,
	output logic [15:0]           frac_s2
);

	// Reduce a count below 48 modulo 6 by compare and subtract
	function automatic logic [2:0] wrap6(input logic [5:0] q);
		logic [5:0] r;
		r = q;
		if (r >= 6'd24) r = r - 6'd24;
		if (r >= 6'd12) r = r - 6'd12;
		if (r >= 6'd6)  r = r - 6'd6;
		return r[2:0];
	endfunction

	logic signed [49:0] prod_full;
	logic signed [48:0] prod_s1;
	logic        [5:0]  turns;

	// Stage 1: hue times 6/pi, Q.44 sextants
	assign prod_full = hue_angle * $signed({1'b0, hsvrgb_pkg::SEXT_SCALE});

	always_ff @(posedge clk) begin
		if (en.s1) begin
			prod_s1 <= prod_full[48:0];
		end
	end

	// Stage 2: floor to whole sextants, lift by 18 to make it positive, wrap mod 6
	assign turns = {prod_s1[48], prod_s1[48:44]} + 6'd18;

	always_ff @(posedge clk) begin
		if (en.s2) begin
			sext_s2 <= hsvrgb_pkg::sextant_t'(wrap6(turns));
			frac_s2 <= prod_s1[43:28];
		end
	end

endmodule

@@ rtl/core/hsvrgb_chan.sv @@
// hsvrgb_chan: chroma, second component, offset and 8-bit scaling (stages 1-4).
// Depends on hsvrgb_pkg; takes sextant and fraction from hsvrgb_hue.
module hsvrgb_chan (
	input  logic                  clk,
	input  hsvrgb_pkg::stage_en_t en,
	input  logic [16:0]           saturation,
	input  logic [16:0]           brightness,
	input  hsvrgb_pkg::sextant_t  sext_s2,
	input  logic [15:0]           frac_s2,
	output logic [7:0]            red_s4,
	output logic [7:0]            green_s4,
	output logic [7:0]            blue_s4
);

	// floor((comp + m) * 255 / 2^48), saturated at 255
	function automatic logic [7:0] chan8(input logic [48:0] comp, input logic [48:0] m);
		logic [48:0] sum;
		logic [56:0] scaled;
		sum    = comp + m;
		scaled = {sum, 8'd0} - {8'd0, sum};
		if (scaled[56]) begin
			return 8'hFF;
		end
		return scaled[55:48];
	endfunction

	logic [16:0] sat_c, bri_c;
	logic [33:0] c_full;
	logic [32:0] c32_s1, c32_s2, c32_s3;
	logic [16:0] bri_s1, bri_s2;
	logic [16:0] xmul;
	logic [49:0] x_full;
	logic [48:0] x48_s3, m48_s3;
	hsvrgb_pkg::sextant_t sext_s3;
	logic [48:0] c48, comp_r, comp_g, comp_b;

	// Stage 1: clamp to 1.0, chroma c = v*s in Q1.32
	assign sat_c  = (saturation > hsvrgb_pkg::ONE_Q16) ? hsvrgb_pkg::ONE_Q16 : saturation;
	assign bri_c  = (brightness > hsvrgb_pkg::ONE_Q16) ? hsvrgb_pkg::ONE_Q16 : brightness;
	assign c_full = sat_c * bri_c;

	always_ff @(posedge clk) begin
		if (en.s1) begin
			c32_s1 <= c_full[32:0];
			bri_s1 <= bri_c;
		end
	end

	// Stage 2: wait for the sextant
	always_ff @(posedge clk) begin
		if (en.s2) begin
			c32_s2 <= c32_s1;
			bri_s2 <= bri_s1;
		end
	end

	// Stage 3: x = c*f on even sextants, c*(1-f) on odd ones; m = v - c (Q1.48)
	assign xmul   = sext_s2[0] ? 17'(hsvrgb_pkg::ONE_Q16 - {1'b0, frac_s2}) : {1'b0, frac_s2};
	assign x_full = c32_s2 * xmul;

	always_ff @(posedge clk) begin
		if (en.s3) begin
			x48_s3  <= x_full[48:0];
			m48_s3  <= {bri_s2, 32'd0} - {c32_s2, 16'd0};
			c32_s3  <= c32_s2;
			sext_s3 <= sext_s2;
		end
	end

	// Stage 4: route components by sextant, add offset, scale to 8 bits
	assign c48 = {c32_s3, 16'd0};

	always_comb begin
		case (sext_s3)
			hsvrgb_pkg::SEXT_RED_YEL: begin
				comp_r = c48;    comp_g = x48_s3; comp_b = '0;
			end
			hsvrgb_pkg::SEXT_YEL_GRN: begin
				comp_r = x48_s3; comp_g = c48;    comp_b = '0;
			end
			hsvrgb_pkg::SEXT_GRN_CYN: begin
				comp_r = '0;     comp_g = c48;    comp_b = x48_s3;
			end
			hsvrgb_pkg::SEXT_CYN_BLU: begin
				comp_r = '0;     comp_g = x48_s3; comp_b = c48;
			end
			hsvrgb_pkg::SEXT_BLU_MAG: begin
				comp_r = x48_s3; comp_g = '0;     comp_b = c48;
			end
			default: begin
				comp_r = c48;    comp_g = '0;     comp_b = x48_s3;
			end
		endcase
	end

	always_ff @(posedge clk) begin
		if (en.s4) begin
			red_s4   <= chan8(comp_r, m48_s3);
			green_s4 <= chan8(comp_g, m48_s3);
			blue_s4  <= chan8(comp_b, m48_s3);
		end
	end

endmodule

@@ rtl/core/hsv_to_rgb_pixel.sv @@
// HSV to RGB pixel converter. Takes one word per clock while the output keeps
// taking results (hue in radians, signed Q3.12; saturation and value in Q1.16,
// clamped to 1.0) and returns 8-bit red, green and blue. Four register stages,
// each holding one word: hue scaling and chroma multiply, sextant wrap,
// second-component multiply, offset and 8-bit scaling. Each stage loads when it
// is empty or its word moves on, so bubbles close up under back-pressure and up
// to four words are held while the output waits.
// Depends on hsvrgb_pkg, hsvrgb_if, hsvrgb_hue and hsvrgb_chan.
module hsv_to_rgb_pixel (
	input  logic               clk,
	input  logic               arst_n,
	hsvrgb_in_if.sink          pix_in,
	hsvrgb_out_if.source       pix_out
);

	hsvrgb_pkg::stage_en_t en;
	hsvrgb_pkg::sextant_t  sext_s2;
	logic [15:0] frac_s2;
	logic        vld_s1, vld_s2, vld_s3, vld_s4;
	logic [7:0]  red_s4, green_s4, blue_s4;

	// Stage load enables: a stage takes a word when empty or when its word leaves
	assign en.s4 = !vld_s4 || pix_out.ready;
	assign en.s3 = !vld_s3 || en.s4;
	assign en.s2 = !vld_s2 || en.s3;
	assign en.s1 = !vld_s1 || en.s2;

	assign pix_in.ready = en.s1;

	// Valid bits travel with the words
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s1 <= 1'b0;
			vld_s2 <= 1'b0;
			vld_s3 <= 1'b0;
			vld_s4 <= 1'b0;
		end else begin
			if (en.s1) vld_s1 <= pix_in.valid;
			if (en.s2) vld_s2 <= vld_s1;
			if (en.s3) vld_s3 <= vld_s2;
			if (en.s4) vld_s4 <= vld_s3;
		end
	end

	hsvrgb_hue u_hue (
		.clk       (clk),
		.en        (en),
		.hue_angle (pix_in.hue_angle),
		.sext_s2   (sext_s2),
		.frac_s2   (frac_s2)
	);

	hsvrgb_chan u_chan (
		.clk        (clk),
		.en         (en),
		.saturation (pix_in.saturation),
		.brightness (pix_in.brightness),
		.sext_s2    (sext_s2),
		.frac_s2    (frac_s2),
		.red_s4     (red_s4),
		.green_s4   (green_s4),
		.blue_s4    (blue_s4)
	);

	assign pix_out.valid = vld_s4;
	assign pix_out.red   = red_s4;
	assign pix_out.green = green_s4;
	assign pix_out.blue  = blue_s4;

endmodule

@@ rtl/core/hsvrgb_checker.sv @@
// hsvrgb_checker: port-level assertions for hsv_to_rgb_pixel, bound to the top.
// Depends on assert_macros.svh.
`include "assert_macros.svh"

module hsvrgb_checker (
	input logic       clk,
	input logic       arst_n,
	input logic       in_valid,
	input logic       in_ready,
	input logic       out_valid,
	input logic       out_ready,
	input logic [7:0] red,
	input logic [7:0] green,
	input logic [7:0] blue
);

	logic [2:0] inflight_q;

	// Words accepted but not yet delivered
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			inflight_q <= 3'd0;
		end else begin
			inflight_q <= inflight_q + {2'd0, in_valid && in_ready}
				- {2'd0, out_valid && out_ready};
		end
	end

	`ASSERT_IMPLIES(a_no_phantom, clk, arst_n, out_valid, inflight_q != 3'd0, "result with no word in flight")
	`ASSERT_IMPLIES(a_depth, clk, arst_n, 1'b1, inflight_q <= 3'd4, "more than four words held")
	`ASSERT_IMPLIES(a_full_stall, clk, arst_n, !in_ready, inflight_q == 3'd4, "input stalled while a stage is free")
	`ASSERT_NEXT(a_out_hold, clk, arst_n, out_valid && !out_ready, out_valid, "result dropped while stalled")
	`ASSERT_NEXT(a_out_stable, clk, arst_n, out_valid && !out_ready, $stable(red) && $stable(green) && $stable(blue), "result changed while stalled")

endmodule

bind hsv_to_rgb_pixel hsvrgb_checker u_hsvrgb_checker (
	.clk       (clk),
	.arst_n    (arst_n),
	.in_valid  (pix_in.valid),
	.in_ready  (pix_in.ready),
	.out_valid (pix_out.valid),
	.out_ready (pix_out.ready),
	.red       (pix_out.red),
	.green     (pix_out.green),
	.blue      (pix_out.blue)
);
